/* rtl/scda_pkg.sv */
`timescale 1ns / 1ps
// Package for the scaled complex dot accumulate block.
// Holds widths, register index codes and the beat types. No dependencies.
package scda_pkg;

  localparam int ELEMENT_BITS = 16;
  localparam int ACC_BITS     = 48;
  localparam int PRIOR_BITS   = 32;
  localparam int RES_BITS     = 32;
  localparam int FRAC_BITS    = ELEMENT_BITS - 1;

  // element product and complex pair sum
  localparam int PROD_BITS  = 2 * ELEMENT_BITS;
  localparam int PAIR_BITS  = PROD_BITS + 1;
  // accumulator rounded to Q.15, one spare bit for the round-up carry
  localparam int RSUM_BITS  = ACC_BITS - FRAC_BITS + 1;
  // scale factor with room for negation
  localparam int SCALE_BITS = ELEMENT_BITS + 1;
  localparam int TERM_BITS  = SCALE_BITS + RSUM_BITS;
  localparam int TOT_BITS   = TERM_BITS + 2;
  localparam int RRES_BITS  = TOT_BITS - FRAC_BITS + 1;

  localparam int CFG_INDEX_BITS = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ALPHA_RE = 4'd0,
    REG_ALPHA_IM = 4'd1,
    REG_BETA_RE  = 4'd2,
    REG_BETA_IM  = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] x_re;
    logic signed [ELEMENT_BITS-1:0] x_im;
    logic signed [ELEMENT_BITS-1:0] y_re;
    logic signed [ELEMENT_BITS-1:0] y_im;
    logic                           has_element;
    logic                           last;
    logic signed [PRIOR_BITS-1:0]   prior_re;
    logic signed [PRIOR_BITS-1:0]   prior_im;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] result_re;
    logic signed [RES_BITS-1:0] result_im;
    logic                       saturated;
  } out_item_t;

endpackage

/* rtl/scaled_complex_dot_accumulate.sv */
`timescale 1ns / 1ps
// Scaled complex dot product with saturating accumulator and alpha/beta output scaling.
// Depends on scda_pkg for widths, register codes and beat types.

// Takes one element beat every cycle, stalling only when the pipe in front of a held
// result is full. Pipeline: product register, accumulator update, scale multiplies, result
// register; a vector's result follows its last beat through each of them in turn. The
// accumulator add-and-clamp is the one feedback loop and sets the one-beat-per-cycle rate.
// Configuration writes are always ready and must only be made with the pipe empty.
module scaled_complex_dot_accumulate (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  scda_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output scda_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [scda_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [scda_pkg::ELEMENT_BITS-1:0]    cfg_data
);
  import scda_pkg::*;

  // configuration
  logic signed [ELEMENT_BITS-1:0] alpha_re, alpha_im, beta_re, beta_im;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_re <= ELEMENT_BITS'((1 << (ELEMENT_BITS - 1)) - 1);
      alpha_im <= '0;
      beta_re  <= '0;
      beta_im  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA_RE: alpha_re <= cfg_data;
        REG_ALPHA_IM: alpha_im <= cfg_data;
        REG_BETA_RE:  beta_re  <= cfg_data;
        REG_BETA_IM:  beta_im  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic p_vld, f_vld, m_vld, o_vld;
  logic p_go, f_rdy, m_rdy, o_rdy;
  logic in_take;

  // product stage
  logic signed [PROD_BITS-1:0]  p_rr, p_ii, p_ri, p_ir;
  logic                         p_has, p_last;
  logic signed [PRIOR_BITS-1:0] p_qr, p_qi;

  // accumulator
  logic signed [ACC_BITS-1:0]   sum_re, sum_im;
  logic                         clip_seen;
  logic signed [PAIR_BITS-1:0]  pr, pi;
  logic signed [ACC_BITS:0]     wide_re, wide_im;
  logic signed [ACC_BITS-1:0]   sum_re_next, sum_im_next;
  logic                         clip_next;

  // final-sum stage
  logic signed [ACC_BITS-1:0]   f_sr, f_si;
  logic signed [PRIOR_BITS-1:0] f_qr, f_qi;
  logic                         f_flag;

  // scale stage
  logic signed [RSUM_BITS-1:0]  rs_re, rs_im;
  logic signed [SCALE_BITS-1:0] ar, ai, br, bi, ai_neg, bi_neg;
  logic signed [TERM_BITS-1:0]  m_re0, m_re1, m_re2, m_re3;
  logic signed [TERM_BITS-1:0]  m_im0, m_im1, m_im2, m_im3;
  logic                         m_flag;

  // result
  logic signed [TOT_BITS-1:0]   tot_re, tot_im;
  logic signed [RRES_BITS-1:0]  rr_re, rr_im;
  logic                         ovf_re, ovf_im;
  logic signed [RES_BITS-1:0]   res_re, res_im;
  out_item_t                    o_data;

  assign o_rdy    = !o_vld || !out_stall;
  assign m_rdy    = !m_vld || o_rdy;
  assign f_rdy    = !f_vld || m_rdy;
  assign p_go     = p_vld && (!p_last || f_rdy);
  assign in_stall = p_vld && !p_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (in_take) begin
      p_vld <= 1'b1;
    end else if (p_go) begin
      p_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      p_rr   <= PROD_BITS'(in_data.x_re) * PROD_BITS'(in_data.y_re);
      p_ii   <= PROD_BITS'(in_data.x_im) * PROD_BITS'(in_data.y_im);
      p_ri   <= PROD_BITS'(in_data.x_re) * PROD_BITS'(in_data.y_im);
      p_ir   <= PROD_BITS'(in_data.x_im) * PROD_BITS'(in_data.y_re);
      p_has  <= in_data.has_element;
      p_last <= in_data.last;
      p_qr   <= in_data.prior_re;
      p_qi   <= in_data.prior_im;
    end
  end

  // saturating accumulate; the exact sum fits one extra bit
  always_comb begin
    pr        = PAIR_BITS'(p_rr) - PAIR_BITS'(p_ii);
    pi        = PAIR_BITS'(p_ri) + PAIR_BITS'(p_ir);
    wide_re   = (ACC_BITS + 1)'(sum_re) + (ACC_BITS + 1)'(pr);
    wide_im   = (ACC_BITS + 1)'(sum_im) + (ACC_BITS + 1)'(pi);
    clip_next = clip_seen;
    if (!p_has) begin
      sum_re_next = sum_re;
      sum_im_next = sum_im;
    end else begin
      if (wide_re[ACC_BITS] != wide_re[ACC_BITS-1]) begin
        sum_re_next = {wide_re[ACC_BITS], {(ACC_BITS - 1){!wide_re[ACC_BITS]}}};
        clip_next   = 1'b1;
      end else begin
        sum_re_next = wide_re[ACC_BITS-1:0];
      end
      if (wide_im[ACC_BITS] != wide_im[ACC_BITS-1]) begin
        sum_im_next = {wide_im[ACC_BITS], {(ACC_BITS - 1){!wide_im[ACC_BITS]}}};
        clip_next   = 1'b1;
      end else begin
        sum_im_next = wide_im[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_re    <= '0;
      sum_im    <= '0;
      clip_seen <= 1'b0;
    end else if (p_go) begin
      if (p_last) begin
        sum_re    <= '0;
        sum_im    <= '0;
        clip_seen <= 1'b0;
      end else begin
        sum_re    <= sum_re_next;
        sum_im    <= sum_im_next;
        clip_seen <= clip_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (p_go && p_last) begin
      f_vld <= 1'b1;
    end else if (m_rdy) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_go && p_last) begin
      f_sr   <= sum_re_next;
      f_si   <= sum_im_next;
      f_qr   <= p_qr;
      f_qi   <= p_qi;
      f_flag <= clip_next;
    end
  end

  // round Q.30 sums to Q.15 (half up) and form the eight scale products
  always_comb begin
    rs_re  = RSUM_BITS'(f_sr >>> FRAC_BITS) + RSUM_BITS'($signed({1'b0, f_sr[FRAC_BITS-1]}));
    rs_im  = RSUM_BITS'(f_si >>> FRAC_BITS) + RSUM_BITS'($signed({1'b0, f_si[FRAC_BITS-1]}));
    ar     = SCALE_BITS'(alpha_re);
    ai     = SCALE_BITS'(alpha_im);
    br     = SCALE_BITS'(beta_re);
    bi     = SCALE_BITS'(beta_im);
    ai_neg = -ai;
    bi_neg = -bi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (m_rdy) begin
      m_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && f_vld) begin
      m_re0  <= TERM_BITS'(ar)     * TERM_BITS'(rs_re);
      m_re1  <= TERM_BITS'(ai_neg) * TERM_BITS'(rs_im);
      m_re2  <= TERM_BITS'(br)     * TERM_BITS'(f_qr);
      m_re3  <= TERM_BITS'(bi_neg) * TERM_BITS'(f_qi);
      m_im0  <= TERM_BITS'(ar)     * TERM_BITS'(rs_im);
      m_im1  <= TERM_BITS'(ai)     * TERM_BITS'(rs_re);
      m_im2  <= TERM_BITS'(br)     * TERM_BITS'(f_qi);
      m_im3  <= TERM_BITS'(bi)     * TERM_BITS'(f_qr);
      m_flag <= f_flag;
    end
  end

  // sum, round half up, clamp to the result width
  always_comb begin
    tot_re = TOT_BITS'(m_re0) + TOT_BITS'(m_re1) + TOT_BITS'(m_re2) + TOT_BITS'(m_re3);
    tot_im = TOT_BITS'(m_im0) + TOT_BITS'(m_im1) + TOT_BITS'(m_im2) + TOT_BITS'(m_im3);
    rr_re  = RRES_BITS'(tot_re >>> FRAC_BITS)
           + RRES_BITS'($signed({1'b0, tot_re[FRAC_BITS-1]}));
    rr_im  = RRES_BITS'(tot_im >>> FRAC_BITS)
           + RRES_BITS'($signed({1'b0, tot_im[FRAC_BITS-1]}));
    ovf_re = (rr_re[RRES_BITS-1:RES_BITS-1] != {(RRES_BITS - RES_BITS + 1){1'b0}})
          && (rr_re[RRES_BITS-1:RES_BITS-1] != {(RRES_BITS - RES_BITS + 1){1'b1}});
    ovf_im = (rr_im[RRES_BITS-1:RES_BITS-1] != {(RRES_BITS - RES_BITS + 1){1'b0}})
          && (rr_im[RRES_BITS-1:RES_BITS-1] != {(RRES_BITS - RES_BITS + 1){1'b1}});
    res_re = ovf_re ? {rr_re[RRES_BITS-1], {(RES_BITS - 1){!rr_re[RRES_BITS-1]}}}
                    : rr_re[RES_BITS-1:0];
    res_im = ovf_im ? {rr_im[RRES_BITS-1], {(RES_BITS - 1){!rr_im[RRES_BITS-1]}}}
                    : rr_im[RES_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (o_rdy) begin
      o_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && m_vld) begin
      o_data.result_re <= res_re;
      o_data.result_im <= res_im;
      o_data.saturated <= m_flag || ovf_re || ovf_im;
    end
  end

  assign out_valid = o_vld;
  assign out_data  = o_data;

  // a closing beat leaves the accumulator clean for the next vector
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    p_go && p_last |=> sum_re == '0 && sum_im == '0 && !clip_seen)
    else $error("accumulator not cleared after last beat");

  a_input_free_when_empty: assert property (@(posedge clk) disable iff (rst)
    !p_vld |-> !in_stall)
    else $error("input stalled with product stage empty");

  a_final_to_scale: assert property (@(posedge clk) disable iff (rst)
    f_vld && m_rdy |=> m_vld)
    else $error("final sum lost on way to scale stage");

  a_scale_to_out: assert property (@(posedge clk) disable iff (rst)
    m_vld && o_rdy |=> out_valid)
    else $error("scaled beat lost on way to output");

endmodule

/* bench/scaled_complex_dot_accumulate_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for scaled_complex_dot_accumulate: directed and random vectors,
// each result predicted in the bench and compared field by field on the result channel.
// Depends on scda_pkg and the scaled_complex_dot_accumulate top level.
module scaled_complex_dot_accumulate_tb;
  import scda_pkg::*;

  localparam int     CYCLE_LIMIT   = 1_000_000;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     PHASE_BEATS   = 330;
  localparam longint ACC_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint RES_MAX = (longint'(1) <<< (RES_BITS - 1)) - 1;
  localparam longint RES_MIN = -RES_MAX - 1;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  in_item_t                   in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  out_item_t                  out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [ELEMENT_BITS-1:0]    cfg_data = '0;

  scaled_complex_dot_accumulate dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  pending_beats[$];
  out_item_t expected_results[$];
  out_item_t oldest_result;

  // bench copy of the scale registers and accumulator
  logic signed [ELEMENT_BITS-1:0] alpha_re_q = 16'sh7fff;
  logic signed [ELEMENT_BITS-1:0] alpha_im_q = '0;
  logic signed [ELEMENT_BITS-1:0] beta_re_q  = '0;
  logic signed [ELEMENT_BITS-1:0] beta_im_q  = '0;
  longint                         dot_sum_re = 0;
  longint                         dot_sum_im = 0;
  bit                             dot_clipped = 1'b0;

  int  send_gap_pct   = 0;
  int  recv_stall_pct = 0;
  bit  in_beat_taken  = 1'b0;
  int  cycle_count    = 0;
  int  error_count    = 0;

  // round half up from Q.30 to Q.15
  function automatic longint round_q15(input longint v);
    return (v >>> FRAC_BITS) + ((v >>> (FRAC_BITS - 1)) & 1);
  endfunction

  function automatic longint acc_clamp(input longint acc, input longint p, inout bit clipped);
    longint s;
    s = acc + p;
    if (s > ACC_MAX) begin
      clipped = 1'b1;
      return ACC_MAX;
    end
    if (s < ACC_MIN) begin
      clipped = 1'b1;
      return ACC_MIN;
    end
    return s;
  endfunction

  function automatic logic signed [RES_BITS-1:0] result_clamp(input longint v, inout bit clipped);
    if (v > RES_MAX) begin
      clipped = 1'b1;
      return RES_MAX[RES_BITS-1:0];
    end
    if (v < RES_MIN) begin
      clipped = 1'b1;
      return RES_MIN[RES_BITS-1:0];
    end
    return v[RES_BITS-1:0];
  endfunction

  function automatic void predict_dot_beat(input in_item_t b);
    longint    xr, xi, yr, yi, sr, si, ar, ai, br, bi, qr, qi, tr, ti;
    bit        flag;
    out_item_t r;
    xr = longint'(b.x_re);
    xi = longint'(b.x_im);
    yr = longint'(b.y_re);
    yi = longint'(b.y_im);
    if (b.has_element) begin
      dot_sum_re = acc_clamp(dot_sum_re, xr * yr - xi * yi, dot_clipped);
      dot_sum_im = acc_clamp(dot_sum_im, xr * yi + xi * yr, dot_clipped);
    end
    if (b.last) begin
      sr = round_q15(dot_sum_re);
      si = round_q15(dot_sum_im);
      ar = longint'(alpha_re_q);
      ai = longint'(alpha_im_q);
      br = longint'(beta_re_q);
      bi = longint'(beta_im_q);
      qr = longint'(b.prior_re);
      qi = longint'(b.prior_im);
      tr = ar * sr - ai * si + br * qr - bi * qi;
      ti = ar * si + ai * sr + br * qi + bi * qr;
      flag = dot_clipped;
      r.result_re = result_clamp(round_q15(tr), flag);
      r.result_im = result_clamp(round_q15(ti), flag);
      r.saturated = flag;
      expected_results.push_back(r);
      dot_sum_re = 0;
      dot_sum_im = 0;
      dot_clipped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 40)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // input driver and result stall, both changing on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_beat_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: predict on each accepted input beat, check each accepted result beat
  always @(posedge clk) begin
    cycle_count++;
    in_beat_taken <= in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        predict_dot_beat(in_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with none pending, re",
                          longint'(out_data.result_re), longint'(0));
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data.result_re !== oldest_result.result_re)
            report_mismatch("result_re", longint'(out_data.result_re),
                            longint'(oldest_result.result_re));
          if (out_data.result_im !== oldest_result.result_im)
            report_mismatch("result_im", longint'(out_data.result_im),
                            longint'(oldest_result.result_im));
          if (out_data.saturated !== oldest_result.saturated)
            report_mismatch("saturated", longint'(out_data.saturated),
                            longint'(oldest_result.saturated));
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [ELEMENT_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ELEMENT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PRIOR_BITS-1:0] pick_prior();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3, 4: return 32'($urandom_range(131071)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_beat(
    input logic [ELEMENT_BITS-1:0] xr, xi, yr, yi,
    input bit he, lst,
    input logic [PRIOR_BITS-1:0] pr, pi
  );
    in_item_t b;
    b.x_re = xr;
    b.x_im = xi;
    b.y_re = yr;
    b.y_im = yi;
    b.has_element = he;
    b.last = lst;
    b.prior_re = pr;
    b.prior_im = pi;
    return b;
  endfunction

  // one vector: mostly short, some empty, a few long; counts beats that do something
  task automatic queue_random_vector(inout int counted);
    int len;
    bit he;
    case ($urandom_range(9))
      0: len = 0;
      1: len = $urandom_range(40, 9);
      default: len = $urandom_range(8, 1);
    endcase
    for (int k = 0; k < len; k++) begin
      he = ($urandom_range(9) != 0);
      pending_beats.push_back(make_beat(pick_sample(), pick_sample(), pick_sample(),
                                        pick_sample(), he, 1'b0, $urandom, $urandom));
      if (he)
        counted++;
    end
    he = (len == 0) ? ($urandom_range(1) == 1) : ($urandom_range(3) != 0);
    pending_beats.push_back(make_beat(pick_sample(), pick_sample(), pick_sample(),
                                      pick_sample(), he, 1'b1, pick_prior(), pick_prior()));
    counted++;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input cfg_reg_t idx, input logic [ELEMENT_BITS-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALPHA_RE: alpha_re_q = v;
      REG_ALPHA_IM: alpha_im_q = v;
      REG_BETA_RE:  beta_re_q  = v;
      REG_BETA_IM:  beta_im_q  = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_scales(input logic [ELEMENT_BITS-1:0] are, aim, bre, bim);
    write_scale(REG_ALPHA_RE, are);
    write_scale(REG_ALPHA_IM, aim);
    write_scale(REG_BETA_RE, bre);
    write_scale(REG_BETA_IM, bim);
  endtask

  initial begin
    int counted;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          2: set_scales(16'h8000, 16'h8000, 16'h8000, 16'h8000);
          3: set_scales(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
          default: set_scales(ELEMENT_BITS'($urandom), ELEMENT_BITS'($urandom),
                              ELEMENT_BITS'($urandom), ELEMENT_BITS'($urandom));
        endcase
      end
      send_gap_pct   = (phase < 2) ? 12 : (phase < 4) ? 74 : 0;
      recv_stall_pct = (phase < 2) ? 74 : (phase < 4) ? 12 : 0;

      if (phase == 0) begin
        // reset scales: alpha just under one, beta zero
        pending_beats.push_back(make_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                          1'b1, 1'b1, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                          1'b1, 1'b1, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'h8000, 16'h0000, 16'h8000, 16'h0000,
                                          1'b1, 1'b1, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b1, 1'b1,
                                          32'h7fffffff, 32'h80000000));
        // empty vector
        pending_beats.push_back(make_beat(16'h1234, 16'h4321, 16'h5555, 16'haaaa, 1'b0, 1'b1,
                                          32'h7fffffff, 32'h80000000));
        // beat with nothing in it is ignored
        pending_beats.push_back(make_beat(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0,
                                          32'hffffffff, 32'hffffffff));
        // exactly half an LSB either side of zero
        pending_beats.push_back(make_beat(16'h0080, 16'h0000, 16'h0080, 16'h0000,
                                          1'b1, 1'b1, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'hff80, 16'h0000, 16'h0080, 16'h0000,
                                          1'b1, 1'b1, 32'd0, 32'd0));
        // three-beat vector, last beat carries no element
        pending_beats.push_back(make_beat(16'h0080, 16'h0000, 16'h0080, 16'h0000,
                                          1'b1, 1'b0, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'h0000, 16'h0080, 16'h0000, 16'h0080,
                                          1'b1, 1'b0, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                          1'b0, 1'b1, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'h04d2, 16'he9d2, 16'hef1f, 16'h223d,
                                          1'b1, 1'b0, 32'd0, 32'd0));
        pending_beats.push_back(make_beat(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b1, 1'b1,
                                          32'h80000000, 32'h7fffffff));
        pending_beats.push_back(make_beat(16'h0001, 16'hffff, 16'hffff, 16'h0001, 1'b1, 1'b1,
                                          32'h00000001, 32'hffffffff));
      end

      counted = 0;
      while (counted < PHASE_BEATS)
        queue_random_vector(counted);
    end

    wait_drained();
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
